>>> rtl/core/lpg_pkg.sv
package lpg_pkg;

  localparam int KIND_W = 3;
  localparam int RATE_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SET_W = 2;
  localparam int WHY_W = 3;
  localparam int WAKE_W = 32;

  // event kinds
  localparam logic [KIND_W-1:0] EV_CONNECT      = 3'd0;
  localparam logic [KIND_W-1:0] EV_DISCONNECT   = 3'd1;
  localparam logic [KIND_W-1:0] EV_UPDATE_START = 3'd2;
  localparam logic [KIND_W-1:0] EV_UPDATE_STOP  = 3'd3;
  localparam logic [KIND_W-1:0] EV_STREAM_START = 3'd4;
  localparam logic [KIND_W-1:0] EV_STREAM_STOP  = 3'd5;
  localparam logic [KIND_W-1:0] EV_ACTIVITY     = 3'd6;
  localparam logic [KIND_W-1:0] EV_TIMER        = 3'd7;

  // parameter sets
  localparam logic [SET_W-1:0] SET_NONE = 2'd0;
  localparam logic [SET_W-1:0] SET_FAST = 2'd1;
  localparam logic [SET_W-1:0] SET_MED  = 2'd2;
  localparam logic [SET_W-1:0] SET_SLOW = 2'd3;

  // reason codes
  localparam logic [WHY_W-1:0] WHY_NONE     = 3'd0;
  localparam logic [WHY_W-1:0] WHY_UPDATE   = 3'd1;
  localparam logic [WHY_W-1:0] WHY_STREAM   = 3'd2;
  localparam logic [WHY_W-1:0] WHY_CONNECT  = 3'd3;
  localparam logic [WHY_W-1:0] WHY_ACTIVITY = 3'd4;
  localparam logic [WHY_W-1:0] WHY_IDLE     = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_HOLD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_FAST_RATE = 2'd3;

  localparam logic [CFG_W-1:0]  RST_IDLE_TIMEOUT     = 32'd30000;
  localparam logic [CFG_W-1:0]  RST_BOOST_HOLD       = 32'd5000;
  localparam logic [CFG_W-1:0]  RST_MIN_SPACING      = 32'd2000;
  localparam logic [RATE_W-1:0] RST_STREAM_FAST_RATE = 16'd10;

  typedef struct packed {
    logic [CFG_W-1:0]  idle_timeout;
    logic [CFG_W-1:0]  boost_hold;
    logic [CFG_W-1:0]  min_spacing;
    logic [RATE_W-1:0] stream_fast_rate;
  } cfg_t;

  typedef struct packed {
    logic [SET_W-1:0]  request;
    logic [WHY_W-1:0]  why;
    logic [WAKE_W-1:0] wake_delay;
  } res_t;

endpackage

>>> rtl/core/lpg_in_if.sv
interface lpg_in_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           kind;
  logic [TIME_BITS-1:0] now_time;
  logic [TIME_BITS-1:0] last_activity;
  logic [15:0]          stream_rate;

  modport source (output valid, kind, now_time, last_activity, stream_rate, input ready);
  modport sink (input valid, kind, now_time, last_activity, stream_rate, output ready);
endinterface

interface lpg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  request;
  logic [2:0]  why;
  logic [31:0] wake_delay;

  modport source (output valid, request, why, wake_delay, input ready);
  modport sink (input valid, request, why, wake_delay, output ready);
endinterface

>>> rtl/core/lpg_cfg_regs.sv
module lpg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0]     cfg_wdata,
  output lpg_pkg::cfg_t                 cfg
);
  import lpg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout     <= RST_IDLE_TIMEOUT;
      cfg_r.boost_hold       <= RST_BOOST_HOLD;
      cfg_r.min_spacing      <= RST_MIN_SPACING;
      cfg_r.stream_fast_rate <= RST_STREAM_FAST_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_TIMEOUT:     cfg_r.idle_timeout <= cfg_wdata;
        REG_BOOST_HOLD:       cfg_r.boost_hold <= cfg_wdata;
        REG_MIN_SPACING:      cfg_r.min_spacing <= cfg_wdata;
        REG_STREAM_FAST_RATE: cfg_r.stream_fast_rate <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

>>> rtl/core/lpg_core.sv
module lpg_core #(
  parameter int TIME_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [lpg_pkg::KIND_W-1:0] kind,
  input  logic [TIME_BITS-1:0]       now_time,
  input  logic [TIME_BITS-1:0]       last_activity,
  input  logic [lpg_pkg::RATE_W-1:0] stream_rate,
  input  lpg_pkg::cfg_t              cfg,
  output lpg_pkg::res_t              res
);
  import lpg_pkg::*;

  logic                 linked_r, linked_nxt;
  logic                 update_hold_r, update_hold_nxt;
  logic                 stream_hold_r, stream_hold_nxt;
  logic [RATE_W-1:0]    held_rate_r, held_rate_nxt;
  logic [SET_W-1:0]     current_set_r, current_set_nxt;
  logic [TIME_BITS-1:0] last_req_time_r, last_req_time_nxt;
  logic                 last_req_valid_r, last_req_valid_nxt;

  logic [SET_W-1:0]     flag_set;
  logic                 flag_req_valid;
  logic [TIME_BITS-1:0] idle, since;
  logic [TIME_BITS-1:0] idle_to, boost_to, spacing;
  logic [SET_W-1:0]     want, timer_from;
  logic [WHY_W-1:0]     why;
  logic                 update_hold_f, stream_hold_f;
  logic                 deferred;
  logic [WAKE_W-1:0]    timer_val;

  // window minus idle fits in 32 bits when the window is larger
  function automatic logic [WAKE_W-1:0] idle_timer(
    input logic [SET_W-1:0]     from,
    input logic                 hold,
    input logic [TIME_BITS-1:0] idle_v,
    input logic [TIME_BITS-1:0] fast_win,
    input logic [TIME_BITS-1:0] med_win
  );
    logic [TIME_BITS-1:0] win;
    logic                 none;
    logic [TIME_BITS-1:0] diff;
    none = 1'b0;
    win  = fast_win;
    if (hold) none = 1'b1;
    else if (from == SET_FAST) win = fast_win;
    else if (from == SET_MED) win = med_win;
    else none = 1'b1;
    diff = win - idle_v;
    if (none) return '0;
    else if (win > idle_v) return diff[WAKE_W-1:0];
    else return WAKE_W'(1);
  endfunction

  always_comb begin
    linked_nxt      = linked_r;
    update_hold_nxt = update_hold_r;
    stream_hold_nxt = stream_hold_r;
    held_rate_nxt   = held_rate_r;
    flag_set        = current_set_r;
    flag_req_valid  = last_req_valid_r;
    case (kind)
      EV_CONNECT, EV_DISCONNECT: begin
        linked_nxt      = (kind == EV_CONNECT);
        update_hold_nxt = 1'b0;
        stream_hold_nxt = 1'b0;
        held_rate_nxt   = '0;
        flag_set        = SET_NONE;
        flag_req_valid  = 1'b0;
      end
      EV_UPDATE_START: update_hold_nxt = 1'b1;
      EV_UPDATE_STOP:  update_hold_nxt = 1'b0;
      EV_STREAM_START: begin
        stream_hold_nxt = 1'b1;
        held_rate_nxt   = stream_rate;
      end
      EV_STREAM_STOP: begin
        stream_hold_nxt = 1'b0;
        held_rate_nxt   = '0;
      end
      default: ;
    endcase
    update_hold_f = update_hold_nxt;
    stream_hold_f = stream_hold_nxt;

    idle     = (last_activity > now_time) ? '0 : now_time - last_activity;
    since    = now_time - last_req_time_r;
    idle_to  = TIME_BITS'(cfg.idle_timeout);
    boost_to = TIME_BITS'(cfg.boost_hold);
    spacing  = TIME_BITS'(cfg.min_spacing);

    if (update_hold_f) want = SET_FAST;
    else if (flag_set == SET_NONE) want = SET_FAST;
    else if (stream_hold_f)
      want = (held_rate_nxt >= cfg.stream_fast_rate) ? SET_FAST : SET_MED;
    else if (flag_set == SET_SLOW && idle < boost_to) want = SET_MED;
    else if (flag_set == SET_FAST && idle >= idle_to) want = SET_SLOW;
    else if (flag_set == SET_MED && idle >= boost_to) want = SET_SLOW;
    else want = flag_set;

    // request time ahead of now never defers
    deferred = flag_req_valid && (now_time >= last_req_time_r) && (since < spacing);

    if (want == SET_FAST)
      why = update_hold_f ? WHY_UPDATE : (stream_hold_f ? WHY_STREAM : WHY_CONNECT);
    else if (want == SET_MED)
      why = stream_hold_f ? WHY_STREAM : WHY_ACTIVITY;
    else
      why = WHY_IDLE;

    timer_from = (want == flag_set || deferred) ? flag_set : want;
    timer_val  = idle_timer(timer_from, update_hold_f || stream_hold_f, idle,
                            idle_to, boost_to);

    current_set_nxt    = flag_set;
    last_req_time_nxt  = last_req_time_r;
    last_req_valid_nxt = flag_req_valid;
    res                = '0;
    if (linked_nxt) begin
      if (want == flag_set) begin
        res.wake_delay = timer_val;
      end else if (deferred) begin
        res.wake_delay = cfg.min_spacing - since[WAKE_W-1:0];
      end else begin
        current_set_nxt    = want;
        last_req_time_nxt  = now_time;
        last_req_valid_nxt = 1'b1;
        res.request        = want;
        res.why            = why;
        res.wake_delay     = timer_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linked_r         <= 1'b0;
      update_hold_r    <= 1'b0;
      stream_hold_r    <= 1'b0;
      held_rate_r      <= '0;
      current_set_r    <= SET_NONE;
      last_req_time_r  <= '0;
      last_req_valid_r <= 1'b0;
    end else if (advance) begin
      linked_r         <= linked_nxt;
      update_hold_r    <= update_hold_nxt;
      stream_hold_r    <= stream_hold_nxt;
      held_rate_r      <= held_rate_nxt;
      current_set_r    <= current_set_nxt;
      last_req_time_r  <= last_req_time_nxt;
      last_req_valid_r <= last_req_valid_nxt;
    end
  end
endmodule

>>> rtl/core/link_param_governor.sv
// an accepted input transaction is held in the input register; its result is offered from the output register
// throughput: one event per cycle; the input register refills in the same cycle its
// item moves to the output register, so only a stalled output holds off the input
// reset (rst_n, synchronous): flags, set and request time cleared, registers back to
// their defaults, both pipeline registers empty
module link_param_governor #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lpg_in_if.sink                        in_ch,
  lpg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0]     cfg_wdata
);
  import lpg_pkg::*;

  cfg_t cfg;
  res_t res;

  logic                 s1_valid_r;
  logic [KIND_W-1:0]    kind_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] last_r;
  logic [RATE_W-1:0]    rate_r;
  logic                 out_valid_r;
  res_t                 out_r;
  logic                 advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  lpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpg_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .kind          (kind_r),
    .now_time      (now_r),
    .last_activity (last_r),
    .stream_rate   (rate_r),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r <= in_ch.kind;
      now_r  <= in_ch.now_time;
      last_r <= in_ch.last_activity;
      rate_r <= in_ch.stream_rate;
    end
    if (advance) out_r <= res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.request    = out_r.request;
  assign out_ch.why        = out_r.why;
  assign out_ch.wake_delay = out_r.wake_delay;
endmodule
